// File: rtl/core/lptt_pkg.sv
// ----------------------------------------------------------------------------
// lptt_pkg
// shared types and constants of the looping playback timeline timer
// ----------------------------------------------------------------------------
`default_nettype none

package lptt_pkg;

   // field widths
   localparam int unsigned TIME_W   = 32;  // q16.16 time values
   localparam int unsigned SPEED_W  = 16;  // q8.8 rate
   localparam int unsigned FRAC_W   = 17;  // q0.16 ratio incl. the value 1.0
   localparam int unsigned ID_W     = 32;
   localparam int unsigned REQ_W    = 3;
   localparam int unsigned CSR_IX_W = 3;

   // product of a signed delta and the 17 bit signed speed
   localparam int unsigned PROD_W   = 48;
   localparam int unsigned STEP_SH  = 8;                 // q24.24 down to q16.16
   localparam int unsigned STEP_W   = PROD_W - STEP_SH;  // signed step
   localparam int unsigned POS_W    = STEP_W + 1;        // signed cursor plus step

   // shared divider
   localparam int unsigned DIV_NUM_W     = 48;
   localparam int unsigned DIV_CNT_W     = 6;
   localparam int unsigned DIV_MOD_STEPS = POS_W;  // full remainder of the wrapped position
   localparam int unsigned DIV_FRAC_STEPS = 16;    // ratio of a value below its divisor

   localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(256);
   localparam logic [FRAC_W-1:0]  FRAC_ONE  = FRAC_W'(65536);

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 3'd0,
      REQ_PLAY   = 3'd1,
      REQ_STOP   = 3'd2,
      REQ_PAUSE  = 3'd3,
      REQ_RESUME = 3'd4,
      REQ_SEEK   = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_STOPPED   = 2'd0,
      MODE_PLAYING   = 2'd1,
      MODE_PAUSED    = 2'd2,
      MODE_FINISHING = 2'd3
   } mode_type;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_LENGTH       = 3'd0,
      CSR_SEQ_VALID    = 3'd1,
      CSR_SPEED        = 3'd2,
      CSR_BLEND_TIME   = 3'd3,
      CSR_LOOP_ENABLE  = 3'd4,
      CSR_HOLD_AT_END  = 3'd5,
      CSR_USE_UNSCALED = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADV,
      ST_MOD,
      ST_NORM,
      ST_NORM_WAIT,
      ST_WGT,
      ST_WGT_WAIT,
      ST_OUT
   } seq_state_type;

   typedef struct packed {
      logic [TIME_W-1:0]  length;
      logic               seq_valid;
      logic [SPEED_W-1:0] speed;
      logic [TIME_W-1:0]  blend_time;
      logic               loop_en;
      logic               hold_en;
      logic               unscaled;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [TIME_W-1:0]    rem_init;
      logic [DIV_NUM_W-1:0] num_init;
      logic [TIME_W-1:0]    divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                    done;
      logic [TIME_W-1:0]       rem;
      logic [DIV_FRAC_STEPS-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/lptt_div.sv
// ----------------------------------------------------------------------------
// lptt_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lptt_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lptt_pkg::div_cmd_type cmd,
   output lptt_pkg::div_rsp_type     rsp
);

   logic [lptt_pkg::TIME_W-1:0]    rem_ff, rem_in;
   logic [lptt_pkg::DIV_NUM_W-1:0] num_ff;
   logic [lptt_pkg::TIME_W-1:0]    div_ff;
   logic [lptt_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           done_ff;

   logic [lptt_pkg::TIME_W:0] trial;
   logic [lptt_pkg::TIME_W:0] diff;
   logic                      ge;

   // partial remainder stays below the divisor, so trial fits one extra bit
   always_comb begin
      trial  = {rem_ff, num_ff[lptt_pkg::DIV_NUM_W-1]};
      ge     = trial >= {1'b0, div_ff};
      diff   = trial - {1'b0, div_ff};
      rem_in = ge ? diff[lptt_pkg::TIME_W-1:0] : trial[lptt_pkg::TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (cmd.start) begin
         cnt_ff  <= cmd.steps;
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == lptt_pkg::DIV_CNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= cmd.rem_init;
         num_ff <= cmd.num_init;
         div_ff <= cmd.divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[lptt_pkg::DIV_NUM_W-2:0], ge};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;
   assign rsp.quo  = num_ff[lptt_pkg::DIV_FRAC_STEPS-1:0];

endmodule

`default_nettype wire

// File: rtl/core/lptt_ctrl.sv
// ----------------------------------------------------------------------------
// lptt_ctrl
// sequencer, playback state and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lptt_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lptt_pkg::cfg_type                   cfg,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lptt_pkg::REQ_W-1:0]          req_type,
   input  wire logic signed [lptt_pkg::TIME_W-1:0]  req_scaled_delta,
   input  wire logic signed [lptt_pkg::TIME_W-1:0]  req_unscaled_delta,
   input  wire logic [lptt_pkg::TIME_W-1:0]         req_seek_target,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_play_state,
   output logic [lptt_pkg::TIME_W-1:0]              rsp_position,
   output logic [lptt_pkg::FRAC_W-1:0]              rsp_normalized_position,
   output logic [lptt_pkg::FRAC_W-1:0]              rsp_blend_weight,
   output logic [lptt_pkg::ID_W-1:0]                rsp_session_id,
   output lptt_pkg::div_cmd_type                    div_cmd,
   input  wire lptt_pkg::div_rsp_type               div_rsp
);

   localparam int unsigned TW = lptt_pkg::TIME_W;
   localparam int unsigned FW = lptt_pkg::FRAC_W;
   localparam int unsigned PW = lptt_pkg::POS_W;

   lptt_pkg::seq_state_type state_ff, state_in;
   lptt_pkg::mode_type      mode_ff, mode_in;

   logic [TW-1:0]                      cursor_ff, cursor_in;
   logic signed [TW-1:0]               elapsed_ff, elapsed_in;
   logic [lptt_pkg::ID_W-1:0]          cur_id_ff, cur_id_in;
   logic [lptt_pkg::ID_W-1:0]          next_id_ff, next_id_in;

   logic [lptt_pkg::REQ_W-1:0]         type_ff, type_in;
   logic signed [TW-1:0]               sd_ff, sd_in;
   logic signed [TW-1:0]               ud_ff, ud_in;
   logic [TW-1:0]                      seek_ff, seek_in;
   logic signed [lptt_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [FW-1:0]                      norm_ff, norm_in;
   logic [FW-1:0]                      weight_ff, weight_in;

   logic                               out_valid_ff, out_valid_in;
   logic [1:0]                         out_state_ff, out_state_in;
   logic [TW-1:0]                      out_pos_ff, out_pos_in;
   logic [FW-1:0]                      out_norm_ff, out_norm_in;
   logic [FW-1:0]                      out_weight_ff, out_weight_in;
   logic [lptt_pkg::ID_W-1:0]          out_id_ff, out_id_in;

   // datapath helpers
   logic [TW-1:0]                      dur;
   logic signed [TW-1:0]               delta;
   logic signed [lptt_pkg::SPEED_W:0]  spd;
   logic signed [lptt_pkg::PROD_W-1:0] prod_full;
   logic signed [TW:0]                 blend_sum;
   logic signed [TW-1:0]               blend_sat;
   logic signed [lptt_pkg::STEP_W-1:0] step;
   logic signed [PW-1:0]               t_sum;
   logic                               t_neg;
   logic                               t_in_range;
   logic                               stop_hit;

   always_comb begin
      dur   = (mode_ff == lptt_pkg::MODE_STOPPED) ? '0 : cfg.length;
      delta = cfg.unscaled ? ud_ff : sd_ff;
      spd   = (cfg.speed == '0) ? $signed({1'b0, lptt_pkg::SPEED_ONE})
                                : $signed({1'b0, cfg.speed});
      // full product of 32 by 17 signed bits always fits 48 signed bits
      prod_full = delta * spd;

      blend_sum = $signed({elapsed_ff[TW-1], elapsed_ff}) + $signed({ud_ff[TW-1], ud_ff});
      if (blend_sum[TW] != blend_sum[TW-1]) begin
         blend_sat = blend_sum[TW] ? $signed({1'b1, {(TW-1){1'b0}}})
                                   : $signed({1'b0, {(TW-1){1'b1}}});
      end else begin
         blend_sat = blend_sum[TW-1:0];
      end

      // arithmetic shift of the product floors toward minus infinity
      step       = prod_ff[lptt_pkg::PROD_W-1:lptt_pkg::STEP_SH];
      t_sum      = $signed({{(PW-TW){1'b0}}, cursor_ff}) + $signed({step[lptt_pkg::STEP_W-1], step});
      t_neg      = t_sum[PW-1];
      t_in_range = !t_neg && (t_sum <= $signed({{(PW-TW){1'b0}}, cfg.length}));
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cursor_in     = cursor_ff;
      elapsed_in    = elapsed_ff;
      cur_id_in     = cur_id_ff;
      next_id_in    = next_id_ff;
      type_in       = type_ff;
      sd_in         = sd_ff;
      ud_in         = ud_ff;
      seek_in       = seek_ff;
      prod_in       = prod_ff;
      norm_in       = norm_ff;
      weight_in     = weight_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_state_in  = out_state_ff;
      out_pos_in    = out_pos_ff;
      out_norm_in   = out_norm_ff;
      out_weight_in = out_weight_ff;
      out_id_in     = out_id_ff;
      req_ready     = 1'b0;
      stop_hit      = 1'b0;
      div_cmd       = '0;

      unique case (state_ff)
         lptt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in  = req_type;
               sd_in    = req_scaled_delta;
               ud_in    = req_unscaled_delta;
               seek_in  = req_seek_target;
               state_in = lptt_pkg::ST_EXEC;
            end
         end

         lptt_pkg::ST_EXEC: begin
            state_in = lptt_pkg::ST_NORM;
            unique case (lptt_pkg::req_code_type'(type_ff))
               lptt_pkg::REQ_TICK: begin
                  if (mode_ff == lptt_pkg::MODE_FINISHING) begin
                     stop_hit = 1'b1;
                  end else if (mode_ff == lptt_pkg::MODE_PLAYING) begin
                     elapsed_in = blend_sat;
                     prod_in    = prod_full;
                     state_in   = lptt_pkg::ST_ADV;
                  end
               end
               lptt_pkg::REQ_PLAY: begin
                  if (!cfg.seq_valid) begin
                     stop_hit = 1'b1;
                  end else begin
                     mode_in    = lptt_pkg::MODE_PLAYING;
                     cursor_in  = '0;
                     elapsed_in = '0;
                     cur_id_in  = next_id_ff;
                     next_id_in = next_id_ff + 1'b1;
                  end
               end
               lptt_pkg::REQ_STOP: begin
                  stop_hit = 1'b1;
               end
               lptt_pkg::REQ_PAUSE: begin
                  if (mode_ff == lptt_pkg::MODE_PLAYING) mode_in = lptt_pkg::MODE_PAUSED;
               end
               lptt_pkg::REQ_RESUME: begin
                  if (mode_ff == lptt_pkg::MODE_PAUSED) mode_in = lptt_pkg::MODE_PLAYING;
               end
               lptt_pkg::REQ_SEEK: begin
                  cursor_in = (seek_ff < dur) ? seek_ff : dur;
               end
               default: ;
            endcase
            if (stop_hit) begin
               mode_in    = lptt_pkg::MODE_STOPPED;
               cursor_in  = '0;
               elapsed_in = '0;
               cur_id_in  = '0;
            end
         end

         lptt_pkg::ST_ADV: begin
            state_in = lptt_pkg::ST_NORM;
            if (cfg.length != '0) begin
               if (t_neg) begin
                  cursor_in = cfg.loop_en ? cfg.length : '0;
               end else if (t_in_range) begin
                  cursor_in = t_sum[TW-1:0];
               end else if (cfg.loop_en) begin
                  div_cmd.start    = 1'b1;
                  div_cmd.steps    = lptt_pkg::DIV_CNT_W'(lptt_pkg::DIV_MOD_STEPS);
                  div_cmd.rem_init = '0;
                  div_cmd.num_init = {t_sum, {(lptt_pkg::DIV_NUM_W-PW){1'b0}}};
                  div_cmd.divisor  = cfg.length;
                  state_in         = lptt_pkg::ST_MOD;
               end else begin
                  cursor_in = cfg.length;
                  mode_in   = cfg.hold_en ? lptt_pkg::MODE_PAUSED : lptt_pkg::MODE_FINISHING;
               end
            end
         end

         lptt_pkg::ST_MOD: begin
            if (div_rsp.done) begin
               cursor_in = div_rsp.rem;
               state_in  = lptt_pkg::ST_NORM;
            end
         end

         lptt_pkg::ST_NORM: begin
            state_in = lptt_pkg::ST_WGT;
            if (dur == '0) begin
               norm_in = '0;
            end else if (cursor_ff >= dur) begin
               norm_in = lptt_pkg::FRAC_ONE;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = lptt_pkg::DIV_CNT_W'(lptt_pkg::DIV_FRAC_STEPS);
               div_cmd.rem_init = cursor_ff;
               div_cmd.num_init = '0;
               div_cmd.divisor  = dur;
               state_in         = lptt_pkg::ST_NORM_WAIT;
            end
         end

         lptt_pkg::ST_NORM_WAIT: begin
            if (div_rsp.done) begin
               norm_in  = {1'b0, div_rsp.quo};
               state_in = lptt_pkg::ST_WGT;
            end
         end

         lptt_pkg::ST_WGT: begin
            state_in = lptt_pkg::ST_OUT;
            if (cfg.blend_time == '0) begin
               weight_in = lptt_pkg::FRAC_ONE;
            end else if (elapsed_ff <= 0) begin
               weight_in = '0;
            end else if ($unsigned(elapsed_ff) >= cfg.blend_time) begin
               weight_in = lptt_pkg::FRAC_ONE;
            end else begin
               div_cmd.start    = 1'b1;
               div_cmd.steps    = lptt_pkg::DIV_CNT_W'(lptt_pkg::DIV_FRAC_STEPS);
               div_cmd.rem_init = $unsigned(elapsed_ff);
               div_cmd.num_init = '0;
               div_cmd.divisor  = cfg.blend_time;
               state_in         = lptt_pkg::ST_WGT_WAIT;
            end
         end

         lptt_pkg::ST_WGT_WAIT: begin
            if (div_rsp.done) begin
               weight_in = {1'b0, div_rsp.quo};
               state_in  = lptt_pkg::ST_OUT;
            end
         end

         lptt_pkg::ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in  = 1'b1;
               out_state_in  = mode_ff;
               out_pos_in    = cursor_ff;
               out_norm_in   = norm_ff;
               out_weight_in = weight_ff;
               out_id_in     = cur_id_ff;
               state_in      = lptt_pkg::ST_IDLE;
            end
         end

         default: state_in = lptt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lptt_pkg::ST_IDLE;
         mode_ff      <= lptt_pkg::MODE_STOPPED;
         cursor_ff    <= '0;
         elapsed_ff   <= '0;
         cur_id_ff    <= '0;
         next_id_ff   <= lptt_pkg::ID_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cursor_ff    <= cursor_in;
         elapsed_ff   <= elapsed_in;
         cur_id_ff    <= cur_id_in;
         next_id_ff   <= next_id_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      sd_ff         <= sd_in;
      ud_ff         <= ud_in;
      seek_ff       <= seek_in;
      prod_ff       <= prod_in;
      norm_ff       <= norm_in;
      weight_ff     <= weight_in;
      out_state_ff  <= out_state_in;
      out_pos_ff    <= out_pos_in;
      out_norm_ff   <= out_norm_in;
      out_weight_ff <= out_weight_in;
      out_id_ff     <= out_id_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_play_state          = out_state_ff;
   assign rsp_position            = out_pos_ff;
   assign rsp_normalized_position = out_norm_ff;
   assign rsp_blend_weight        = out_weight_ff;
   assign rsp_session_id          = out_id_ff;

endmodule

`default_nettype wire

// File: rtl/core/looping_playback_timeline_timer_top.sv
// ----------------------------------------------------------------------------
// looping_playback_timeline_timer_top
// playback position timer with loop, hold and finish handling at the end
// ----------------------------------------------------------------------------
//
//   channel   ports                    role
//   --------  -----------------------  ---------------------------------------
//   req       req_valid / req_ready    command item in (tick, play, stop, ...)
//   rsp       rsp_valid / rsp_ready    status item out, one per command
//   csr       csr_wr_en                register write, taken at once
//
// one item at a time; a tick without wrap runs the shared divider for
//   16 steps each for normalized position and blend weight
// a looping tick past the end also runs it for the modulo first
// ratios known to be 0 or 1.0 up front skip the divider and save its cycles
// reset is synchronous: stopped, position 0, session ids restart at 1
// the result register lets the next item in while a result waits for rsp_ready
// ----------------------------------------------------------------------------
`default_nettype none

module looping_playback_timeline_timer_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // command items
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [lptt_pkg::REQ_W-1:0]            req_type,
   input  wire logic signed [lptt_pkg::TIME_W-1:0]    req_scaled_delta,
   input  wire logic signed [lptt_pkg::TIME_W-1:0]    req_unscaled_delta,
   input  wire logic [lptt_pkg::TIME_W-1:0]           req_seek_target,
   // status items
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_play_state,
   output logic [lptt_pkg::TIME_W-1:0]                rsp_position,
   output logic [lptt_pkg::FRAC_W-1:0]                rsp_normalized_position,
   output logic [lptt_pkg::FRAC_W-1:0]                rsp_blend_weight,
   output logic [lptt_pkg::ID_W-1:0]                  rsp_session_id,
   // register writes
   input  wire logic                                  csr_wr_en,
   input  wire logic [lptt_pkg::CSR_IX_W-1:0]         csr_index,
   input  wire logic [lptt_pkg::TIME_W-1:0]           csr_wdata
);

   lptt_pkg::cfg_type     cfg_ff, cfg_in;
   lptt_pkg::div_cmd_type div_cmd;
   lptt_pkg::div_rsp_type div_rsp;

   // register file, read live by the sequencer
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (lptt_pkg::csr_index_type'(csr_index))
            lptt_pkg::CSR_LENGTH:       cfg_in.length     = csr_wdata;
            lptt_pkg::CSR_SEQ_VALID:    cfg_in.seq_valid  = csr_wdata[0];
            lptt_pkg::CSR_SPEED:        cfg_in.speed      = csr_wdata[lptt_pkg::SPEED_W-1:0];
            lptt_pkg::CSR_BLEND_TIME:   cfg_in.blend_time = csr_wdata;
            lptt_pkg::CSR_LOOP_ENABLE:  cfg_in.loop_en    = csr_wdata[0];
            lptt_pkg::CSR_HOLD_AT_END:  cfg_in.hold_en    = csr_wdata[0];
            lptt_pkg::CSR_USE_UNSCALED: cfg_in.unscaled   = csr_wdata[0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // all clear but the speed, which resets to 1.0 in q8.8
         cfg_ff <= '{length:     '0,
                     seq_valid:  1'b0,
                     speed:      lptt_pkg::SPEED_ONE,
                     blend_time: '0,
                     loop_en:    1'b0,
                     hold_en:    1'b0,
                     unscaled:   1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer with mode, cursor, blend time, session ids and result register
   lptt_ctrl u_ctrl (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg_ff),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_type                (req_type),
      .req_scaled_delta        (req_scaled_delta),
      .req_unscaled_delta      (req_unscaled_delta),
      .req_seek_target         (req_seek_target),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_play_state          (rsp_play_state),
      .rsp_position            (rsp_position),
      .rsp_normalized_position (rsp_normalized_position),
      .rsp_blend_weight        (rsp_blend_weight),
      .rsp_session_id          (rsp_session_id),
      .div_cmd                 (div_cmd),
      .div_rsp                 (div_rsp)
   );

   // one divider serves the loop modulo and both q0.16 ratios
   lptt_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

endmodule

`default_nettype wire

// File: rtl/core/lptt_checker.sv
// ----------------------------------------------------------------------------
// lptt_checker
// port level checks of the playback timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lptt_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic [lptt_pkg::REQ_W-1:0]         req_type,
   input  wire logic [lptt_pkg::TIME_W-1:0]        req_scaled_delta,
   input  wire logic [lptt_pkg::TIME_W-1:0]        req_unscaled_delta,
   input  wire logic [lptt_pkg::TIME_W-1:0]        req_seek_target,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [1:0]                         rsp_play_state,
   input  wire logic [lptt_pkg::TIME_W-1:0]        rsp_position,
   input  wire logic [lptt_pkg::FRAC_W-1:0]        rsp_normalized_position,
   input  wire logic [lptt_pkg::FRAC_W-1:0]        rsp_blend_weight,
   input  wire logic [lptt_pkg::ID_W-1:0]          rsp_session_id,
   input  wire logic                               csr_wr_en,
   input  wire logic [lptt_pkg::CSR_IX_W-1:0]      csr_index,
   input  wire logic [lptt_pkg::TIME_W-1:0]        csr_wdata
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_session_id) && $stable(rsp_play_state))
      else $error("result changed while stalled");

   // one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   // stopped means no session and the cursor at zero
   a_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_play_state == lptt_pkg::MODE_STOPPED |->
         rsp_session_id == '0 && rsp_position == '0 && rsp_normalized_position == '0)
      else $error("stopped result carries a session or position");

   // ratios never pass 1.0
   a_ratio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normalized_position <= lptt_pkg::FRAC_ONE
         && rsp_blend_weight <= lptt_pkg::FRAC_ONE)
      else $error("ratio above 1.0");

endmodule

bind looping_playback_timeline_timer_top lptt_checker u_checker (.*);

`default_nettype wire
